// ----- design/rms_pkg.sv -----
package rms_pkg;

  // Opcode of an input request.
  localparam logic OpSchedule = 1'b0;
  localparam logic OpTick     = 1'b1;

  // Kind of a result.
  localparam logic ResultStatus = 1'b0;
  localparam logic ResultEmit   = 1'b1;

  // Configuration register map.
  localparam int  PaddrW            = 3;
  localparam logic RegRepeatCount    = 1'b0;
  localparam logic RegRepeatInterval = 1'b1;

  localparam logic [3:0]  RepeatCountRst    = 4'd2;
  localparam logic [15:0] RepeatIntervalRst = 16'd20;

  // A tick emits at most this many messages.
  localparam int MaxResults = 16;
  localparam int NumW       = 5;
  // Copy counter holds repeat_count + 1.
  localparam int CopyW      = 5;

  // Queue depths between the parts.
  localparam int CmdDepth = 2;
  localparam int ResDepth = 2;

  typedef struct packed {
    logic        op;
    logic [31:0] now_ms;
    logic [1:0]  msg_kind;
    logic [7:0]  unit_index;
    logic        onoff_value;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic       dropped;
    logic [1:0] out_kind;
    logic [7:0] out_index;
    logic       out_value;
    logic [7:0] out_tid;
    logic       last;
  } out_item_t;

  typedef enum logic {
    CmdSchedule,
    CmdTick
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] now_ms;
    logic [1:0]  msg_kind;
    logic [7:0]  unit_index;
    logic        onoff_value;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  repeat_count;
    logic [15:0] repeat_interval;
  } cfg_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkPlace,
    BkStatus,
    BkScan,
    BkLast
  } back_state_e;

endpackage

// ----- design/repeat_message_spooler_unit.sv -----
// Timed message spooler with a table of SLOT_COUNT slots. Each request is either a
// schedule or a tick. A schedule bumps the 8-bit transaction id and places
// repeat_count+1 copies of the message in the lowest free slots, copy i due at
// now_ms + i*repeat_interval; it always returns one status result (last set) that
// echoes the message, carries the new id and flags dropped when the table ran out of
// free slots. A tick returns every occupied slot whose due time is at or before
// now_ms, in slot order, at most 16 per tick, frees them, and sets last on the final
// one; a tick with nothing due returns nothing. One request is worked at a time by a
// sequencer that visits one slot per clock while the result side does not hold it off:
// a schedule walks the slots to place its copies and then returns its status, and a
// tick scans them through the single read port of the slot memory, checks the
// occupancy bits and due times, and then hands out its last result. A two-entry
// request queue in front and a two-entry result queue behind let the producer and the
// consumer stall independently of the sequencer. Slot occupancy is cleared by reset
// at once, so no clearing pass is needed. The configuration registers sit at byte
// addresses 0 (repeat_count) and 4 (repeat_interval) and should only be written
// while the block is idle.
module repeat_message_spooler_unit #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request side.
  input  logic                          push,
  output logic                          full,
  input  rms_pkg::in_item_t             in_item_i,
  // Result side.
  output logic                          empty,
  input  logic                          pop,
  output rms_pkg::out_item_t            res_item_o,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rms_pkg::PaddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  import rms_pkg::*;

  cfg_t      cfg_q;
  logic      cfg_wr;
  logic      cmd_valid, cmd_pop;
  cmd_t      cmd;
  logic      res_push, res_full;
  out_item_t res_data;
  logic [$bits(out_item_t)-1:0] res_bits;

  // The configuration port never inserts wait states. A write lands in the
  // access phase; the register is picked by address bit 2.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_count    <= RepeatCountRst;
      cfg_q.repeat_interval <= RepeatIntervalRst;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegRepeatCount:    cfg_q.repeat_count    <= pwdata[3:0];
        RegRepeatInterval: cfg_q.repeat_interval <= pwdata[15:0];
        default:           cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegRepeatCount:    prdata = {28'd0, cfg_q.repeat_count};
      RegRepeatInterval: prdata = {16'd0, cfg_q.repeat_interval};
      default:           prdata = '0;
    endcase
  end

  // The front decodes and queues requests so the producer is not held up
  // while the sequencer scans the table.
  rms_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  // The back owns the slot table and the scan sequencer.
  rms_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_data_o  (res_data)
  );

  // Results wait here until the consumer pops them; the sequencer only
  // stalls when this queue is full.
  rms_fifo #(
    .DW    ($bits(out_item_t)),
    .DEPTH (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_data),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_bits),
    .empty_o (empty)
  );

  assign res_item_o = out_item_t'(res_bits);

`ifndef SYNTHESIS
  // The sequencer must never hand a result to a full result queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result pushed into a full queue");

  // A request is only taken from the front when one is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> cmd_valid)
    else $error("request popped from an empty queue");

  // A schedule status is always the only, and so the last, result of its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && (res_data.result_kind == ResultStatus)) |-> res_data.last)
    else $error("status result without last");

  // Emitted messages never report a drop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && (res_data.result_kind == ResultEmit)) |-> !res_data.dropped)
    else $error("emitted message flagged as dropped");
`endif

endmodule

// ----- design/rms_fifo.sv -----
module rms_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [DW-1:0]   mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- design/rms_front.sv -----
module rms_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rms_pkg::in_item_t item_i,
  output logic              full_o,
  input  logic              cmd_pop_i,
  output logic              cmd_valid_o,
  output rms_pkg::cmd_t     cmd_o
);

  import rms_pkg::*;

  cmd_t                  cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_bits;
  logic                  cmd_empty;

  // Decode the opcode into a command and pass the payload along.
  always_comb begin
    cmd_in.cmd         = (item_i.op == OpTick) ? CmdTick : CmdSchedule;
    cmd_in.now_ms      = item_i.now_ms;
    cmd_in.msg_kind    = item_i.msg_kind;
    cmd_in.unit_index  = item_i.unit_index;
    cmd_in.onoff_value = item_i.onoff_value;
  end

  rms_fifo #(
    .DW    ($bits(cmd_t)),
    .DEPTH (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_bits),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;
  assign cmd_o       = cmd_t'(cmd_bits);

endmodule

// ----- design/rms_back.sv -----
module rms_back #(
  parameter int SLOT_COUNT = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rms_pkg::cfg_t      cfg_i,
  input  logic               cmd_valid_i,
  input  rms_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output rms_pkg::out_item_t res_data_o
);

  import rms_pkg::*;

  localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CntW = $clog2(SLOT_COUNT + 1);

  typedef struct packed {
    logic [31:0] due;
    logic [1:0]  kind;
    logic [7:0]  index;
    logic        value;
    logic [7:0]  tid;
  } slot_t;

  back_state_e     state_q, state_d;
  cmd_t            cur_q;
  logic [7:0]      tid_q;
  logic [CntW-1:0] pos_q;
  logic [CopyW-1:0] copy_q, copy_n;
  logic [31:0]     due_q;
  logic            drop_q;
  logic            chk_vld_q;
  logic [IdxW-1:0] chk_idx_q;
  logic            hold_vld_q;
  out_item_t       hold_q;
  logic [NumW-1:0] num_q;
  logic [SLOT_COUNT-1:0] valid_q;

  slot_t slot_mem [SLOT_COUNT];
  slot_t rd_q;

  logic [IdxW-1:0] pos_idx;
  logic place_free, all_placed, pos_end;
  logic issue_more, hit, stall, scan_done;
  logic wr_en, rd_en, set_en, clr_en;

  assign pos_idx    = pos_q[IdxW-1:0];
  assign place_free = !valid_q[pos_idx];
  assign copy_n     = copy_q + CopyW'(place_free);
  assign all_placed = copy_n > {1'b0, cfg_i.repeat_count};
  assign pos_end    = (pos_q == CntW'(SLOT_COUNT - 1));

  // Scan pipeline: the slot read is registered, and the compare runs the next cycle.
  assign issue_more = (pos_q != CntW'(SLOT_COUNT));
  assign hit        = chk_vld_q && valid_q[chk_idx_q] && (cur_q.now_ms >= rd_q.due)
                      && (num_q < NumW'(MaxResults));
  assign stall      = hit && hold_vld_q && res_full_i;
  assign scan_done  = !issue_more && !chk_vld_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.cmd == CmdTick) ? BkScan : BkPlace;
        end
      end
      BkPlace: begin
        if (all_placed || pos_end) begin
          state_d = BkStatus;
        end
      end
      BkStatus: begin
        if (!res_full_i) begin
          state_d = BkIdle;
        end
      end
      BkScan: begin
        if (scan_done) begin
          state_d = BkLast;
        end
      end
      BkLast: begin
        if (!hold_vld_q || !res_full_i) begin
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_comb begin
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_data_o = hold_q;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    set_en     = 1'b0;
    clr_en     = 1'b0;
    case (state_q)
      BkIdle: begin
        cmd_pop_o = cmd_valid_i;
      end
      BkPlace: begin
        wr_en  = place_free;
        set_en = place_free;
      end
      BkStatus: begin
        res_push_o             = !res_full_i;
        res_data_o.result_kind = ResultStatus;
        res_data_o.dropped     = drop_q;
        res_data_o.out_kind    = cur_q.msg_kind;
        res_data_o.out_index   = cur_q.unit_index;
        res_data_o.out_value   = cur_q.onoff_value;
        res_data_o.out_tid     = tid_q;
        res_data_o.last        = 1'b1;
      end
      BkScan: begin
        rd_en = issue_more && !stall;
        if (hit && !stall) begin
          clr_en     = 1'b1;
          res_push_o = hold_vld_q;
        end
      end
      BkLast: begin
        res_push_o      = hold_vld_q && !res_full_i;
        res_data_o.last = 1'b1;
      end
      default: begin
        cmd_pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BkIdle;
      tid_q      <= '0;
      pos_q      <= '0;
      copy_q     <= '0;
      drop_q     <= 1'b0;
      chk_vld_q  <= 1'b0;
      chk_idx_q  <= '0;
      hold_vld_q <= 1'b0;
      num_q      <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        BkIdle: begin
          if (cmd_valid_i) begin
            pos_q      <= '0;
            copy_q     <= '0;
            chk_vld_q  <= 1'b0;
            hold_vld_q <= 1'b0;
            num_q      <= '0;
            if (cmd_i.cmd == CmdSchedule) begin
              tid_q <= tid_q + 8'd1;
            end
          end
        end
        BkPlace: begin
          pos_q <= pos_q + 1'b1;
          if (place_free) begin
            copy_q <= copy_n;
          end
          if (all_placed || pos_end) begin
            drop_q <= !all_placed;
          end
        end
        BkScan: begin
          if (!stall) begin
            chk_vld_q <= issue_more;
            chk_idx_q <= pos_idx;
            if (issue_more) begin
              pos_q <= pos_q + 1'b1;
            end
            if (hit) begin
              hold_vld_q <= 1'b1;
              num_q      <= num_q + 1'b1;
            end
          end
        end
        default: begin
          num_q <= num_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BkIdle && cmd_valid_i) begin
      cur_q <= cmd_i;
      due_q <= cmd_i.now_ms;
    end else if (state_q == BkPlace && place_free) begin
      due_q <= due_q + {16'd0, cfg_i.repeat_interval};
    end
    if (state_q == BkScan && hit && !stall) begin
      hold_q.result_kind <= ResultEmit;
      hold_q.dropped     <= 1'b0;
      hold_q.out_kind    <= rd_q.kind;
      hold_q.out_index   <= rd_q.index;
      hold_q.out_value   <= rd_q.value;
      hold_q.out_tid     <= rd_q.tid;
      hold_q.last        <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (set_en) begin
        valid_q[pos_idx] <= 1'b1;
      end
      if (clr_en) begin
        valid_q[chk_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[pos_idx] <= {due_q, cur_q.msg_kind, cur_q.unit_index, cur_q.onoff_value, tid_q};
    end
    if (rd_en) begin
      rd_q <= slot_mem[pos_idx];
    end
  end

endmodule

// ----- sim/repeat_message_spooler_unit_tb.sv -----
module repeat_message_spooler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rms_pkg::*;

  localparam int SlotCount     = 16;
  localparam int ItemsPerPhase = 18;
  localparam int PhaseCount    = 5;
  // Idle mode switches after these many requests (about a third of the run each).
  localparam int IdleSwapAt    = 36;
  localparam int IdleOffAt     = 72;
  // A few requests may sit in the front queue and the sequencer without causing a
  // result, so this many cycles cover the tail of the work.
  localparam int DrainCycles   = 80;
  localparam int CycleLimit    = 300000;

  // Message kinds as they travel in msg_kind and out_kind.
  localparam logic [1:0] KindAckSet   = 2'd0;
  localparam logic [1:0] KindUnackSet = 2'd1;
  localparam logic [1:0] KindGet      = 2'd2;
  localparam logic [1:0] KindSpare    = 2'd3;

  // The scoreboard keeps its own copy of the slot table and the registers. Every
  // accepted request is played against that copy and the results it must cause are
  // queued in order; every popped result is compared with the oldest one.
  class spooler_scoreboard;
    logic [3:0]  repeat_count;
    logic [15:0] repeat_interval;
    bit          slot_busy[SlotCount];
    logic [31:0] slot_due[SlotCount];
    logic [1:0]  slot_kind[SlotCount];
    logic [7:0]  slot_index[SlotCount];
    logic        slot_value[SlotCount];
    logic [7:0]  slot_tid[SlotCount];
    logic [7:0]  tid_counter;
    out_item_t   awaited_results[$];
    int          mismatches;
    int          results_checked;
    int          dropped_statuses;

    function new();
      repeat_count    = RepeatCountRst;
      repeat_interval = RepeatIntervalRst;
      tid_counter     = '0;
      foreach (slot_busy[s]) slot_busy[s] = 1'b0;
      mismatches       = 0;
      results_checked  = 0;
      dropped_statuses = 0;
    endfunction

    function void set_register(logic reg_sel, logic [31:0] value);
      if (reg_sel == RegRepeatCount) begin
        repeat_count = value[3:0];
      end else begin
        repeat_interval = value[15:0];
      end
    endfunction

    function void predict_request(in_item_t req);
      out_item_t res;
      out_item_t held;
      bit        have_held;
      bit        copy_lost;
      int        slot;
      if (req.op == OpSchedule) begin
        tid_counter = tid_counter + 8'd1;
        copy_lost   = 1'b0;
        slot        = 0;
        // Copies go to the lowest free slots; copies that find none are lost.
        for (int i = 0; i <= repeat_count; i++) begin
          while (slot < SlotCount && slot_busy[slot]) slot++;
          if (slot >= SlotCount) begin
            copy_lost = 1'b1;
            break;
          end
          slot_busy[slot]  = 1'b1;
          slot_due[slot]   = req.now_ms + 32'(i) * 32'(repeat_interval);
          slot_kind[slot]  = req.msg_kind;
          slot_index[slot] = req.unit_index;
          slot_value[slot] = req.onoff_value;
          slot_tid[slot]   = tid_counter;
        end
        res.result_kind = ResultStatus;
        res.dropped     = copy_lost;
        res.out_kind    = req.msg_kind;
        res.out_index   = req.unit_index;
        res.out_value   = req.onoff_value;
        res.out_tid     = tid_counter;
        res.last        = 1'b1;
        if (copy_lost) dropped_statuses++;
        awaited_results.push_back(res);
      end else begin
        // Each due message is held back one step so that the final one can be
        // given its last flag before it is queued.
        have_held = 1'b0;
        slot      = 0;
        for (int emitted = 0; slot < SlotCount && emitted < MaxResults; slot++) begin
          if (slot_busy[slot] && req.now_ms >= slot_due[slot]) begin
            if (have_held) awaited_results.push_back(held);
            held.result_kind = ResultEmit;
            held.dropped     = 1'b0;
            held.out_kind    = slot_kind[slot];
            held.out_index   = slot_index[slot];
            held.out_value   = slot_value[slot];
            held.out_tid     = slot_tid[slot];
            held.last        = 1'b0;
            have_held        = 1'b1;
            slot_busy[slot]  = 1'b0;
            emitted++;
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          awaited_results.push_back(held);
        end
      end
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at result %0d: %s", results_checked, what);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      want = awaited_results.pop_front();
      if (got.result_kind !== want.result_kind)
        report_mismatch($sformatf("result_kind %h, want %h", got.result_kind, want.result_kind));
      if (got.dropped !== want.dropped)
        report_mismatch($sformatf("dropped %h, want %h", got.dropped, want.dropped));
      if (got.out_kind !== want.out_kind)
        report_mismatch($sformatf("out_kind %h, want %h", got.out_kind, want.out_kind));
      if (got.out_index !== want.out_index)
        report_mismatch($sformatf("out_index %h, want %h", got.out_index, want.out_index));
      if (got.out_value !== want.out_value)
        report_mismatch($sformatf("out_value %h, want %h", got.out_value, want.out_value));
      if (got.out_tid !== want.out_tid)
        report_mismatch($sformatf("out_tid %h, want %h", got.out_tid, want.out_tid));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %h, want %h", got.last, want.last));
      results_checked++;
    endtask
  endclass

  // Every input of the block starts at a known value; reset is held from time zero.
  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              push      = 1'b0;
  in_item_t          in_item_i = '0;
  logic              pop       = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [PaddrW-1:0] paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic              full;
  logic              empty;
  out_item_t         res_item_o;
  logic [31:0]       prdata;
  logic              pready;

  spooler_scoreboard sb;
  int unsigned cycle_count    = 0;
  int          tx_idle_pct    = 25;
  int          rx_idle_pct    = 53;
  int          requests_sent  = 0;
  int          schedules_sent = 0;
  int          ticks_sent     = 0;
  int          settings_used  = 1;
  // Running time line of the well-formed part of the random stimulus.
  logic [31:0] wall_ms        = 32'd0;

  repeat_message_spooler_unit #(
    .SLOT_COUNT(SlotCount)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .empty     (empty),
    .pop       (pop),
    .res_item_o(res_item_o),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk_i = ~clk_i;

  // A run that hangs anywhere is ended here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               sb.awaited_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side. The values seen right after an edge are the ones the block saw at
  // that edge, so a result counts as taken when pop was high and empty was low. pop
  // gets exactly one new value per edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) sb.check_result(res_item_o);
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offers one request, waits until it is taken, then idles at random with push low;
  // push is still high on return only if no idle came. A request that follows at once
  // keeps push high, so push is never lowered and raised within one time step.
  task automatic push_request(in_item_t req);
    if (requests_sent >= IdleOffAt) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end else if (requests_sent >= IdleSwapAt) begin
      tx_idle_pct = 53;
      rx_idle_pct = 25;
    end
    push      <= 1'b1;
    in_item_i <= req;
    do @(posedge clk_i); while (full);
    sb.predict_request(req);
    requests_sent++;
    if (req.op == OpSchedule) schedules_sent++;
    else ticks_sent++;
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Waits until every awaited result has come and then gives the block time to finish
  // requests that cause none, such as a tick with nothing due.
  task automatic wait_idle();
    push <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes one register with a setup and an access phase, then reads it back. The
  // port is left idle at the end.
  task automatic write_register(logic reg_sel, logic [31:0] value);
    logic [31:0] readback_want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(reg_sel, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback_want = (reg_sel == RegRepeatCount) ? {28'd0, sb.repeat_count}
                                                : {16'd0, sb.repeat_interval};
    if (prdata !== readback_want)
      sb.report_mismatch($sformatf("register %0d reads %h, want %h", reg_sel, prdata,
                                   readback_want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic in_item_t schedule_item(logic [31:0] now, logic [1:0] kind,
                                             logic [7:0] unit, logic value);
    in_item_t req;
    req.op          = OpSchedule;
    req.now_ms      = now;
    req.msg_kind    = kind;
    req.unit_index  = unit;
    req.onoff_value = value;
    return req;
  endfunction

  function automatic in_item_t tick_item(logic [31:0] now);
    in_item_t req;
    req             = '0;
    req.op          = OpTick;
    req.now_ms      = now;
    // The message fields of a tick carry no meaning, so they get random content.
    req.msg_kind    = 2'($urandom_range(3));
    req.unit_index  = 8'($urandom);
    req.onoff_value = 1'($urandom_range(1));
    return req;
  endfunction

  // Most random requests follow a time line that moves forward by steps of the order
  // of the repeat interval, so that copies fall due a few at a time and the table both
  // fills and drains. Some requests jump the time line close to the top of the range,
  // where due times wrap, and some carry an arbitrary time as noise.
  function automatic in_item_t random_request();
    int unsigned pick;
    logic [31:0] span;
    logic [31:0] now;
    pick = $urandom_range(99);
    span = 32'(sb.repeat_interval) * 3 + 32'd5;
    if (pick < 15) begin
      now = $urandom;
    end else begin
      if (pick < 20) begin
        wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 32'(sb.repeat_interval) * 4 + 50);
      end else if (pick < 60) begin
        wall_ms = wall_ms + $urandom_range(0, span);
      end
      now = wall_ms;
    end
    if ($urandom_range(99) < 50) begin
      return tick_item(now);
    end
    return schedule_item(now, 2'($urandom_range(3)), 8'($urandom), 1'($urandom_range(1)));
  endfunction

  // The directed part runs with the reset register values: three copies, 20 ms apart.
  task automatic run_directed();
    // A tick on an empty table causes nothing.
    push_request(tick_item(32'd0));
    // Copies due at 100, 120 and 140: one early tick, one exact, then the rest.
    push_request(schedule_item(32'd100, KindAckSet, 8'd0, 1'b0));
    push_request(tick_item(32'd99));
    push_request(tick_item(32'd100));
    push_request(tick_item(32'hFFFF_FFFF));
    // The unused kind near the top of time: the second copy wraps past zero and goes out
    // on the tick at 5, the first and the third on the tick at the end of time.
    push_request(schedule_item(32'hFFFF_FFF0, KindSpare, 8'hFF, 1'b1));
    push_request(tick_item(32'd5));
    push_request(tick_item(32'hFFFF_FFFF));
    // Seven schedules of three copies overrun the table: the sixth loses copies and the
    // seventh places none. Then all sixteen slots fall due on a single tick.
    for (int k = 0; k < 7; k++) begin
      push_request(schedule_item(32'd1000, 2'(k % 4), 8'(k * 37), 1'(k)));
    end
    push_request(tick_item(32'hFFFF_FFFF));
    push_request(schedule_item(32'd0, KindUnackSet, 8'h80, 1'b1));
    push_request(schedule_item(32'd0, KindGet, 8'h7F, 1'b0));
    push_request(tick_item(32'd40));
  endtask

  initial begin
    logic [3:0]  count_setting;
    logic [15:0] interval_setting;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // Each phase runs under its own register setting, the extremes among them.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: begin
          count_setting    = 4'd15;
          interval_setting = 16'd0;
        end
        1: begin
          count_setting    = 4'd0;
          interval_setting = 16'hFFFF;
        end
        2: begin
          count_setting    = 4'($urandom_range(15));
          interval_setting = 16'($urandom_range(1, 300));
        end
        3: begin
          count_setting    = 4'd15;
          interval_setting = 16'hFFFF;
        end
        default: begin
          count_setting    = 4'($urandom_range(15));
          interval_setting = 16'($urandom);
        end
      endcase
      wait_idle();
      write_register(RegRepeatCount, {28'd0, count_setting});
      write_register(RegRepeatInterval, {16'd0, interval_setting});
      settings_used++;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        push_request(random_request());
      end
    end

    wait_idle();
    $display("Summary: %0d requests (%0d schedules, %0d ticks) under %0d register settings.",
             requests_sent, schedules_sent, ticks_sent, settings_used);
    $display("Summary: %0d results checked, %0d schedules lost copies, %0d mismatches.",
             sb.results_checked, sb.dropped_statuses, sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/rms_pkg.sv
design/rms_fifo.sv
design/rms_front.sv
design/rms_back.sv
design/repeat_message_spooler_unit.sv
sim/repeat_message_spooler_unit_tb.sv
